/* hdl/joint_distance_vote_detector_macros.svh */
// Assertion macros for the joint distance vote detector.
// Needs i_clk and i_rst_n in the scope where a macro is used.
`ifndef JOINT_DISTANCE_VOTE_DETECTOR_MACROS_SVH
`define JOINT_DISTANCE_VOTE_DETECTOR_MACROS_SVH

// same-cycle implication
`define JDVD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define JDVD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/jdvd_pkg.sv */
// Types and constants for the joint distance vote detector.
// No dependencies.
package jdvd_pkg;

    localparam int DIST_W     = 17;
    localparam int CNT_W      = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;
    localparam int SQRT_STEPS = 18;
    localparam int RAD_W      = 36;
    localparam int REM_W      = 20;
    localparam int ROOT_W     = 18;
    localparam int ITER_W     = 5;

    localparam logic [DIST_W-1:0] DIST_MAX = 17'h1FFFF;
    localparam logic [CNT_W-1:0]  CNT_MAX  = 5'd31;

    typedef struct packed {
        logic [11:0] box_left;
        logic [11:0] box_top;
        logic [11:0] box_width;
        logic [11:0] box_height;
        logic [4:0]  joint_index;
        logic [15:0] joint_x;
        logic [15:0] joint_y;
        logic [7:0]  joint_conf;
    } t_in_item;

    typedef struct packed {
        logic       throw_detected;
        logic [4:0] vote_count;
        logic [4:0] counted_joints;
    } t_out_item;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TRACK_CONF_MIN   = 3'd0,
        CFG_INIT_CONF_MIN    = 3'd1,
        CFG_LEARN_KEEP       = 3'd2,
        CFG_INIT_SPREAD_FRAC = 3'd3,
        CFG_MIN_JOINTS       = 3'd4,
        CFG_VOTE_RATIO       = 3'd5,
        CFG_DEFAULT_SPREAD   = 3'd6
    } t_cfg_index;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_SQX,
        S_SQY,
        S_SQRT,
        S_DIST,
        S_JOINT,
        S_DECIDE,
        S_UPD_RD,
        S_UPD_MUL,
        S_UPD_WR
    } t_state;

    typedef struct packed {
        logic load;
        logic clr_cnt;
        logic diff;
        logic sq_x;
        logic sq_y;
        logic sqrt_step;
        logic dist_ld;
        logic joint;
        logic emit;
        logic upd_start;
        logic upd_sel;
        logic upd_mul;
        logic upd_wr;
    } t_dp_cmd;

    typedef struct packed {
        logic idx_ok;
        logic first;
        logic last;
        logic sqrt_done;
        logic out_busy;
        logic thrown;
        logic upd_last;
    } t_dp_status;

endpackage

/* hdl/joint_distance_vote_detector.sv */
// Top level of the joint distance vote detector: sequencer plus datapath.
// Depends on jdvd_pkg, jdvd_ctrl, jdvd_dp.
//
//  channel | valid        | ready        | beat
//  --------+--------------+--------------+--------------------------------
//  input   | i_in_valid   | o_in_ready   | i_in_data   (t_in_item)
//  result  | o_out_valid  | i_out_ready  | o_out_data  (t_out_item)
//  config  | i_cfg_valid  | o_cfg_ready  | i_cfg_index, i_cfg_data
//
// A joint runs through the check, the squaring states for x and y, the 18-step square root
// loop and the distance and joint states. The last joint adds the decision state,
// plus the learning pass over the stores when no throw is reported, one entry per
// read-multiply-write round. An out-of-range joint index goes from the check
// straight back to idle. No clearing pass after reset.
// A stalled result holds the last joint in the decision state until taken.
module joint_distance_vote_detector import jdvd_pkg::*; #(
    parameter int JOINTS = 18
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    assign o_cfg_ready = 1'b1;

    jdvd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    jdvd_dp #(
        .JOINTS (JOINTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

/* hdl/jdvd_ctrl.sv */
// Sequencer for the joint distance vote detector.
// Depends on jdvd_pkg.
module jdvd_ctrl import jdvd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_CHECK;
            end
            S_CHECK:  n_state = i_status.idx_ok ? S_SQX : S_IDLE;
            S_SQX:    n_state = S_SQY;
            S_SQY:    n_state = S_SQRT;
            S_SQRT: begin
                if (i_status.sqrt_done) n_state = S_DIST;
            end
            S_DIST:   n_state = S_JOINT;
            S_JOINT:  n_state = i_status.last ? S_DECIDE : S_IDLE;
            S_DECIDE: begin
                if (!i_status.out_busy) n_state = i_status.thrown ? S_IDLE : S_UPD_RD;
            end
            S_UPD_RD:  n_state = S_UPD_MUL;
            S_UPD_MUL: n_state = S_UPD_WR;
            S_UPD_WR:  n_state = i_status.upd_last ? S_IDLE : S_UPD_RD;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_CHECK: begin
                o_cmd.diff    = 1'b1;
                o_cmd.clr_cnt = i_status.idx_ok & i_status.first;
            end
            S_SQX:  o_cmd.sq_x = 1'b1;
            S_SQY:  o_cmd.sq_y = 1'b1;
            S_SQRT: o_cmd.sqrt_step = 1'b1;
            S_DIST: o_cmd.dist_ld = 1'b1;
            S_JOINT: o_cmd.joint = 1'b1;
            S_DECIDE: begin
                o_cmd.emit      = !i_status.out_busy;
                o_cmd.upd_start = !i_status.out_busy;
            end
            S_UPD_RD: o_cmd.upd_sel = 1'b1;
            S_UPD_MUL: begin
                o_cmd.upd_sel = 1'b1;
                o_cmd.upd_mul = 1'b1;
            end
            S_UPD_WR: begin
                o_cmd.upd_sel = 1'b1;
                o_cmd.upd_wr  = 1'b1;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

/* hdl/jdvd_dp.sv */
// Datapath: config registers, distance, iterative square root, joint stores,
// vote counters, learning update and output register. Depends on jdvd_pkg.
module jdvd_dp import jdvd_pkg::*; #(
    parameter int JOINTS = 18
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_status,
    input  t_in_item              i_in_data,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data
);

    localparam int IDX_W = (JOINTS > 1) ? $clog2(JOINTS) : 1;

    // config
    logic [7:0]        r_track_min;
    logic [7:0]        r_init_min;
    logic [15:0]       r_keep;
    logic [15:0]       r_init_frac;
    logic [5:0]        r_min_joints;
    logic [3:0]        r_ratio;
    logic [DIST_W-1:0] r_default_spread;

    // item
    t_in_item          r_in;
    logic [IDX_W-1:0]  r_idx;
    logic [DIST_W-1:0] r_dx;
    logic [DIST_W-1:0] r_dy;
    logic [33:0]       r_sq;
    logic [RAD_W-1:0]  r_rad;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [ITER_W-1:0] r_iter;
    logic [DIST_W-1:0] r_dist;

    // stores
    logic [DIST_W-1:0] mem_mean   [JOINTS];
    logic [DIST_W-1:0] mem_spread [JOINTS];
    logic [DIST_W-1:0] mem_od     [JOINTS];
    logic [DIST_W-1:0] mem_os     [JOINTS];
    logic [JOINTS-1:0] r_valid;
    logic [DIST_W-1:0] r_rd_mean;
    logic [DIST_W-1:0] r_rd_spread;
    logic [DIST_W-1:0] r_rd_od;
    logic [DIST_W-1:0] r_rd_os;
    logic              r_rd_valid;

    logic [CNT_W-1:0]  r_votes;
    logic [CNT_W-1:0]  r_counted;
    logic [IDX_W-1:0]  r_ui;

    logic [32:0]       r_pma;
    logic [33:0]       r_pmb;
    logic [32:0]       r_psa;
    logic [33:0]       r_psb;

    logic              r_out_valid;
    t_out_item         r_out;

    // combinational
    logic [12:0]       w_cx;
    logic [12:0]       w_cy;
    logic [DIST_W-1:0] w_cx4;
    logic [DIST_W-1:0] w_cy4;
    logic [DIST_W-1:0] w_jx;
    logic [DIST_W-1:0] w_jy;
    logic [DIST_W-1:0] w_sq_op;
    logic [33:0]       w_sq;
    logic [REM_W+1:0]  w_rem_sh;
    logic [REM_W+1:0]  w_trial;
    logic              w_ge;
    logic [IDX_W-1:0]  w_rd_addr;
    logic [IDX_W-1:0]  w_wr_addr;
    logic [DIST_W-1:0] w_mean;
    logic [DIST_W-1:0] w_spread;
    logic              w_conf_ok;
    logic              w_learned;
    logic              w_init;
    logic              w_vote;
    logic [DIST_W-1:0] w_excess;
    logic [33:0]       w_init_sum;
    logic [DIST_W-1:0] w_comp;
    logic [34:0]       w_learn_m;
    logic [34:0]       w_learn_s;
    logic              w_upd_ok;
    logic [8:0]        w_vote_prod;
    logic              w_thrown;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_track_min      <= 8'd76;
            r_init_min       <= 8'd127;
            r_keep           <= 16'd62259;
            r_init_frac      <= 16'd3277;
            r_min_joints     <= 6'd8;
            r_ratio          <= 4'd3;
            r_default_spread <= 17'd160;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_TRACK_CONF_MIN:   r_track_min      <= i_cfg_data[7:0];
                CFG_INIT_CONF_MIN:    r_init_min       <= i_cfg_data[7:0];
                CFG_LEARN_KEEP:       r_keep           <= i_cfg_data[15:0];
                CFG_INIT_SPREAD_FRAC: r_init_frac      <= i_cfg_data[15:0];
                CFG_MIN_JOINTS:       r_min_joints     <= i_cfg_data[5:0];
                CFG_VOTE_RATIO:       r_ratio          <= i_cfg_data[3:0];
                CFG_DEFAULT_SPREAD:   r_default_spread <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_cx  = {1'b0, r_in.box_left} + {2'b00, r_in.box_width[11:1]};
    assign w_cy  = {1'b0, r_in.box_top} + {2'b00, r_in.box_height[11:1]};
    assign w_cx4 = {w_cx, 4'b0000};
    assign w_cy4 = {w_cy, 4'b0000};
    assign w_jx  = {1'b0, r_in.joint_x};
    assign w_jy  = {1'b0, r_in.joint_y};

    assign w_sq_op = i_cmd.sq_x ? r_dx : r_dy;
    assign w_sq    = w_sq_op * w_sq_op;

    assign w_rem_sh = {r_rem, r_rad[RAD_W-1 -: 2]};
    assign w_trial  = {2'b00, r_root, 2'b01};
    assign w_ge     = (w_rem_sh >= w_trial);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_in_data;
        end
        if (i_cmd.diff) begin
            r_idx <= r_in.joint_index[IDX_W-1:0];
            r_dx  <= (w_jx > w_cx4) ? w_jx - w_cx4 : w_cx4 - w_jx;
            r_dy  <= (w_jy > w_cy4) ? w_jy - w_cy4 : w_cy4 - w_jy;
        end
        if (i_cmd.sq_x) begin
            r_sq <= w_sq;
        end
        if (i_cmd.sq_y) begin
            r_rad  <= {1'b0, 35'(r_sq) + 35'(w_sq)};
            r_rem  <= '0;
            r_root <= '0;
            r_iter <= '0;
        end
        if (i_cmd.sqrt_step) begin
            r_rem  <= w_ge ? REM_W'(w_rem_sh - w_trial) : w_rem_sh[REM_W-1:0];
            r_root <= {r_root[ROOT_W-2:0], w_ge};
            r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
            r_iter <= r_iter + 1'b1;
        end
        if (i_cmd.dist_ld) begin
            r_dist <= (r_root > ROOT_W'(DIST_MAX)) ? DIST_MAX : r_root[DIST_W-1:0];
        end
    end

    // store access
    assign w_rd_addr = i_cmd.upd_sel ? r_ui : r_idx;
    assign w_wr_addr = i_cmd.upd_wr ? r_ui : r_idx;

    assign w_mean    = r_rd_valid ? r_rd_mean : '0;
    assign w_spread  = r_rd_valid ? r_rd_spread : '0;
    assign w_conf_ok = r_in.joint_conf > r_track_min;
    assign w_excess  = (r_dist > w_mean) ? r_dist - w_mean : '0;
    assign w_learned = (w_mean != '0);
    assign w_init    = w_conf_ok && !w_learned && (r_in.joint_conf > r_init_min);
    assign w_vote    = {1'b0, w_excess} > {w_spread, 1'b0};
    assign w_init_sum = 34'(r_dist * r_init_frac) + 34'd32768;

    assign w_comp    = 17'h10000 - {1'b0, r_keep};
    assign w_learn_m = 35'(r_pma) + 35'(r_pmb) + 35'd32768;
    assign w_learn_s = 35'(r_psa) + 35'(r_psb) + 35'd32768;
    assign w_upd_ok  = r_rd_valid && (r_rd_mean != '0);

    always_ff @(posedge i_clk) begin
        r_rd_mean   <= mem_mean[w_rd_addr];
        r_rd_spread <= mem_spread[w_rd_addr];
        r_rd_od     <= mem_od[w_rd_addr];
        r_rd_os     <= mem_os[w_rd_addr];
        if (i_cmd.joint) begin
            mem_od[w_wr_addr] <= w_conf_ok ? r_dist : '0;
            mem_os[w_wr_addr] <= w_conf_ok ? w_excess : r_default_spread;
        end
        if (i_cmd.joint && w_init) begin
            mem_mean[w_wr_addr]   <= r_dist;
            mem_spread[w_wr_addr] <= w_init_sum[32:16];
        end
        if (i_cmd.upd_wr && w_upd_ok) begin
            mem_mean[w_wr_addr] <= w_learn_m[32:16];
            if (r_rd_os != '0) begin
                mem_spread[w_wr_addr] <= w_learn_s[32:16];
            end
        end
        if (i_cmd.upd_mul) begin
            r_pma <= r_rd_mean * r_keep;
            r_pmb <= r_rd_od * w_comp;
            r_psa <= r_rd_spread * r_keep;
            r_psb <= r_rd_os * w_comp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= r_valid[w_rd_addr];
            if (i_cmd.joint && w_init) begin
                r_valid[w_wr_addr] <= 1'b1;
            end
        end
    end

    // votes and decision
    assign w_vote_prod = r_votes * r_ratio;
    assign w_thrown    = (w_vote_prod > 9'(r_counted)) && ({1'b0, r_counted} > r_min_joints);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_votes   <= '0;
            r_counted <= '0;
            r_ui      <= '0;
        end else begin
            if (i_cmd.clr_cnt || i_cmd.emit) begin
                r_votes   <= '0;
                r_counted <= '0;
            end else if (i_cmd.joint && w_conf_ok && w_learned) begin
                if (r_counted != CNT_MAX) r_counted <= r_counted + 1'b1;
                if (w_vote && r_votes != CNT_MAX) r_votes <= r_votes + 1'b1;
            end
            if (i_cmd.upd_start) begin
                r_ui <= '0;
            end else if (i_cmd.upd_wr) begin
                r_ui <= IDX_W'(r_ui + 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.throw_detected <= w_thrown;
            r_out.vote_count     <= r_votes;
            r_out.counted_joints <= r_counted;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign o_status.idx_ok    = {1'b0, r_in.joint_index} < 6'(JOINTS);
    assign o_status.first     = (r_in.joint_index == '0);
    assign o_status.last      = {1'b0, r_in.joint_index} == 6'(JOINTS - 1);
    assign o_status.sqrt_done = (r_iter == ITER_W'(SQRT_STEPS - 1));
    assign o_status.out_busy  = r_out_valid;
    assign o_status.thrown    = w_thrown;
    assign o_status.upd_last  = (r_ui == IDX_W'(JOINTS - 1));

endmodule

/* hdl/jdvd_checker.sv */
// Port-level checks for the joint distance vote detector, bound to the top.
// Depends on jdvd_pkg and joint_distance_vote_detector_macros.svh.
`include "joint_distance_vote_detector_macros.svh"

module jdvd_checker import jdvd_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data
);

    `JDVD_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data), "result beat dropped or changed while stalled")
    `JDVD_ASSERT_NOW(a_votes_le_counted, o_out_valid, o_out_data.vote_count <= o_out_data.counted_joints, "more votes than counted joints")
    `JDVD_ASSERT_NOW(a_throw_needs_votes, o_out_valid && o_out_data.throw_detected, o_out_data.vote_count != 5'd0 && o_out_data.counted_joints != 5'd0, "throw without votes")
    `JDVD_ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready, "input taken again right after a beat")

endmodule

bind joint_distance_vote_detector jdvd_checker u_jdvd_checker (.*);

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for joint_distance_vote_detector: directed joints, then random
// frames checked beat by beat against an in-bench model of the joint vote and learning.
// Depends on jdvd_pkg and the joint_distance_vote_detector RTL.
module testbench;
    import jdvd_pkg::*;

    localparam int NJ        = 18;
    localparam int LIMIT     = 1000000;
    localparam int SETTLE    = 120;
    localparam int RAND_GOAL = 700;

    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item want;
    } dir_row_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_in_item              i_in_data = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_item             o_out_data;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    joint_distance_vote_detector #(.JOINTS(NJ)) dut (.*);

    // model of the block
    logic [7:0]  m_track, m_init;
    logic [15:0] m_keep, m_frac;
    logic [5:0]  m_min;
    logic [3:0]  m_ratio;
    logic [16:0] m_dflt;
    logic [16:0] mean_mem [NJ];
    logic [16:0] spread_mem [NJ];
    logic [16:0] obs_dist [NJ];
    logic [16:0] obs_spread [NJ];
    int unsigned votes, counted;

    t_out_item verdict_q [$];
    int        errors = 0;
    int        results_seen = 0;
    int        beats_sent = 0;
    int        cycles = 0;

    int          burst_left = 0;
    int          hold_left = 0;
    bit          hold_done = 0;
    int          rx_mode = 0;
    logic [15:0] base_x [NJ];
    logic [15:0] base_y [NJ];
    logic [11:0] sc_left, sc_top, sc_wid, sc_hei;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned res = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic logic [16:0] blend(logic [16:0] old, logic [16:0] obs);
        longint unsigned s;
        s = longint'(old) * m_keep + longint'(obs) * (65536 - m_keep) + 32768;
        return 17'((s >> 16) & 17'h1FFFF);
    endfunction

    task automatic model_reset();
        m_track = 76; m_init = 127; m_keep = 62259; m_frac = 3277;
        m_min = 8; m_ratio = 3; m_dflt = 160;
        for (int i = 0; i < NJ; i++) begin
            mean_mem[i] = 0; spread_mem[i] = 0; obs_dist[i] = 0; obs_spread[i] = 0;
        end
        votes = 0; counted = 0;
    endtask

    task automatic model_cfg(t_cfg_index idx, logic [16:0] val);
        case (idx)
            CFG_TRACK_CONF_MIN:   m_track = val[7:0];
            CFG_INIT_CONF_MIN:    m_init = val[7:0];
            CFG_LEARN_KEEP:       m_keep = val[15:0];
            CFG_INIT_SPREAD_FRAC: m_frac = val[15:0];
            CFG_MIN_JOINTS:       m_min = val[5:0];
            CFG_VOTE_RATIO:       m_ratio = val[3:0];
            CFG_DEFAULT_SPREAD:   m_dflt = val;
            default: ;
        endcase
    endtask

    // returns 1 when the joint closes a frame and a verdict was queued
    function automatic bit judge_joint(t_in_item it);
        int unsigned j;
        longint unsigned cx, cy, dx, dy, d;
        logic [16:0] dist_v, mu, excess;
        t_out_item v;
        bit thrown;
        j = it.joint_index;
        if (j >= NJ) return 0;
        if (j == 0) begin
            votes = 0; counted = 0;
        end
        if (it.joint_conf > m_track) begin
            cx = (longint'(it.box_left) + (it.box_width >> 1)) << 4;
            cy = (longint'(it.box_top) + (it.box_height >> 1)) << 4;
            dx = it.joint_x > cx ? it.joint_x - cx : cx - it.joint_x;
            dy = it.joint_y > cy ? it.joint_y - cy : cy - it.joint_y;
            d = isqrt(dx * dx + dy * dy);
            dist_v = d > 64'h1FFFF ? 17'h1FFFF : 17'(d);
            mu = mean_mem[j];
            excess = dist_v > mu ? dist_v - mu : 17'd0;
            obs_dist[j] = dist_v;
            obs_spread[j] = excess;
            if (mu == 0) begin
                if (it.joint_conf > m_init) begin
                    mean_mem[j] = dist_v;
                    spread_mem[j] = 17'(((longint'(dist_v) * m_frac) + 32768) >> 16);
                end
            end else begin
                if (longint'(excess) > 2 * longint'(spread_mem[j]) && votes < 31) votes++;
                if (counted < 31) counted++;
            end
        end else begin
            obs_dist[j] = 0;
            obs_spread[j] = m_dflt;
        end
        if (j != NJ - 1) return 0;
        thrown = (votes * m_ratio > counted) && (counted > m_min);
        v.throw_detected = thrown;
        v.vote_count = 5'(votes);
        v.counted_joints = 5'(counted);
        if (!thrown) begin
            for (int i = 0; i < NJ; i++) begin
                if (mean_mem[i] != 0) begin
                    mean_mem[i] = blend(mean_mem[i], obs_dist[i]);
                    if (obs_spread[i] != 0) spread_mem[i] = blend(spread_mem[i], obs_spread[i]);
                end
            end
        end
        votes = 0; counted = 0;
        verdict_q.push_back(v);
        return 1;
    endfunction

    task automatic report(string what, int got, int want);
        $display("MISMATCH at %0t: %s got %0d want %0d", $time, what, got, want);
        errors++;
    endtask

    task automatic send_joint(t_in_item it, output bit closed);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, 30);
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(1, 20);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (!o_in_ready);
        burst_left--;
        if (burst_left == 0) i_in_valid <= 1'b0;
        closed = judge_joint(it);
        if (it.joint_index < NJ) beats_sent++;
    endtask

    task automatic drain();
        if (burst_left != 0) i_in_valid <= 1'b0;
        burst_left = 0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_index idx, logic [16:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        model_cfg(idx, val);
    endtask

    task automatic program_phase(int p);
        logic [16:0] v [7];
        case (p)
            0: v = '{76, 127, 62259, 3277, 8, 3, 160};
            1: v = '{0, 0, 0, 0, 0, 0, 0};
            2: v = '{255, 255, 65535, 65535, 63, 15, 17'h1FFFF};
            3: v = '{76, 127, 32768, 3277, 4, 2, 160};
            default: v = '{$urandom_range(40, 150), $urandom_range(100, 200),
                           $urandom_range(40000, 65535), $urandom, $urandom_range(0, 32),
                           $urandom_range(1, 15), $urandom_range(0, 17'h1FFFF)};
        endcase
        // upper data bits beyond a register's width are don't-care
        v[0] |= 17'($urandom_range(0, 1) << 8);
        for (int i = 0; i <= int'(CFG_DEFAULT_SPREAD); i++) write_reg(t_cfg_index'(i), v[i]);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic new_scene();
        sc_left = $urandom_range(0, 3000);
        sc_top = $urandom_range(0, 3000);
        sc_wid = $urandom_range(20, 1000);
        sc_hei = $urandom_range(20, 1000);
        for (int i = 0; i < NJ; i++) begin
            base_x[i] = 16'(((sc_left + sc_wid / 2) * 16 + $urandom_range(0, 4000)) - 2000);
            base_y[i] = 16'(((sc_top + sc_hei / 2) * 16 + $urandom_range(0, 4000)) - 2000);
        end
    endtask

    task automatic send_frame();
        t_in_item it;
        bit throw_fr, broken, closed;
        int jitter;
        throw_fr = ($urandom_range(0, 5) == 0);
        broken = ($urandom_range(0, 9) == 0);
        jitter = $urandom_range(2, 60);
        for (int j = 0; j < NJ; j++) begin
            if (broken && $urandom_range(0, 5) == 0) continue;
            if (broken && $urandom_range(0, 5) == 0) begin
                it = t_in_item'({$urandom, $urandom, $urandom});
                send_joint(it, closed);
            end
            it.box_left = sc_left;
            it.box_top = sc_top;
            it.box_width = sc_wid;
            it.box_height = sc_hei;
            it.joint_index = 5'(j);
            it.joint_x = 16'(base_x[j] + $urandom_range(0, 2 * jitter) - jitter);
            it.joint_y = 16'(base_y[j] + $urandom_range(0, 2 * jitter) - jitter);
            if (throw_fr && $urandom_range(0, 3) != 0) begin
                it.joint_x = 16'(it.joint_x + $urandom_range(1500, 6000));
                it.joint_y = 16'(it.joint_y - $urandom_range(1500, 6000));
            end
            it.joint_conf = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(200, 255));
            send_joint(it, closed);
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (verdict_q.size() == 0) begin
                report("unexpected result beat, vote_count", o_out_data.vote_count, -1);
            end else begin
                want = verdict_q.pop_front();
                if (o_out_data.throw_detected !== want.throw_detected)
                    report("throw_detected", o_out_data.throw_detected, want.throw_detected);
                if (o_out_data.vote_count !== want.vote_count)
                    report("vote_count", o_out_data.vote_count, want.vote_count);
                if (o_out_data.counted_joints !== want.counted_joints)
                    report("counted_joints", o_out_data.counted_joints, want.counted_joints);
            end
        end
    end

    // result side stalls; one long hold-off to back the block up
    always @(posedge i_clk) begin
        if (cycles % 128 == 0) rx_mode <= $urandom_range(0, 3);
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && results_seen >= 15 && i_in_valid) begin
            hold_done <= 1'b1;
            hold_left <= 600;
            i_out_ready <= 1'b0;
        end else begin
            case (rx_mode)
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= $urandom_range(0, 1);
                2: i_out_ready <= ($urandom_range(0, 9) == 0);
                default: i_out_ready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("joint_distance_vote_detector verification failed");
            $finish;
        end
    end

    initial begin
        dir_row_t rows [10];
        bit closed;
        t_out_item got;
        model_reset();
        rows = '{
            '{'{12'd0, 12'd0, 12'd0, 12'd0, 5'd17, 16'd0, 16'd0, 8'd0}, 1, '{1'b0, 5'd0, 5'd0}},
            '{'{12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 5'd18, 16'hFFFF, 16'hFFFF, 8'hFF}, 0, '0},
            '{'{12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 5'd31, 16'hFFFF, 16'hFFFF, 8'hFF}, 0, '0},
            '{'{12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 5'd0, 16'd0, 16'd0, 8'hFF}, 0, '0},
            '{'{12'd0, 12'd0, 12'd0, 12'd0, 5'd17, 16'hFFFF, 16'hFFFF, 8'hFF}, 1,
              '{1'b0, 5'd0, 5'd0}},
            '{'{12'd100, 12'd100, 12'd0, 12'd0, 5'd0, 16'd1600, 16'd1600, 8'd200}, 0, '0},
            '{'{12'd100, 12'd100, 12'd40, 12'd60, 5'd1, 16'd1000, 16'd2000, 8'd100}, 0, '0},
            '{'{12'd100, 12'd100, 12'd40, 12'd60, 5'd2, 16'd3000, 16'd900, 8'd76}, 0, '0},
            '{'{12'd100, 12'd100, 12'd40, 12'd60, 5'd3, 16'd1800, 16'd1900, 8'd77}, 0, '0},
            '{'{12'd0, 12'd0, 12'd0, 12'd0, 5'd17, 16'd0, 16'd0, 8'd128}, 0, '0}
        };
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (rows[r]) begin
            send_joint(rows[r].item, closed);
            if (closed && rows[r].typed) begin
                got = verdict_q.pop_back();
                verdict_q.push_back(rows[r].want);
            end
        end
        drain();
        for (int p = 0; beats_sent < RAND_GOAL; p++) begin
            program_phase(p);
            new_scene();
            repeat (6) send_frame();
            drain();
        end
        if (errors == 0) begin
            $display("joint_distance_vote_detector verification clean");
        end else begin
            $display("joint_distance_vote_detector verification failed");
        end
        $finish;
    end
endmodule
